FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top level RTL file of the vanishing point core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition implies another at the same clock edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/lpvp_pkg.sv
// Constants, types and the sine table builder of the vanishing point core.
package lpvp_pkg;

  localparam int MAX_LINES = 64;
  localparam int ANGLE_BITS = 12;
  localparam int DIST_FRAC_BITS = 4;

  localparam int DIST_W = 16;
  localparam int CFG_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W = 16;
  localparam int TOTAL_W = 13;

  localparam int ANGLE_N = 1 << ANGLE_BITS;
  localparam int ANGLE_H = 1 << (ANGLE_BITS - 1);
  localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int FILL_W = $clog2(MAX_LINES + 1);
  localparam int CNT_W = $clog2(MAX_LINES * MAX_LINES + 1);
  localparam int SUM_W = OUT_W + CNT_W;
  localparam int ENTRY_W = DIST_W + ANGLE_BITS;

  localparam int Q_W = 16;
  localparam int QS_W = Q_W + 1;
  localparam int P_W = 2 * QS_W;
  localparam int SH = 15 - DIST_FRAC_BITS;
  localparam int NUM_W = P_W + SH;
  localparam int DEN_W = P_W;
  localparam int QB = 15;
  localparam int STEP_W = $clog2(QB);
  localparam int CMP_W = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;

  localparam int REG_LEFT_MIN = 0;
  localparam int REG_LEFT_MAX = 1;
  localparam int REG_RIGHT_MIN = 2;
  localparam int REG_RIGHT_MAX = 3;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam longint unsigned TermDiv [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  typedef logic [Q_W-1:0] sin_rom_t [0:ANGLE_H];

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [OUT_W-1:0] quot;
  } div_resp_t;

  function automatic sin_rom_t build_sin_rom();
    sin_rom_t rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint sum;
    for (int k = 0; k <= ANGLE_H; k++) begin
      x = (longint'(k) * PI_Q30) >> ANGLE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x2) >> 30;
        term = term / TermDiv[n];
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (longint'(sum) + 16384) >> 15;
      if (r > 32768) begin
        r = 32768;
      end
      rom[k] = Q_W'(r);
    end
    return rom;
  endfunction

endpackage

FILE: hw/rtl/lpvp_sin_rom.sv
// Quarter-wave Q15 sine table with a registered read port.
module lpvp_sin_rom (
  input  logic                              clk,
  input  logic [lpvp_pkg::ANGLE_BITS-1:0]   addr,
  output logic [lpvp_pkg::Q_W-1:0]          data
);

  localparam lpvp_pkg::sin_rom_t SIN_ROM = lpvp_pkg::build_sin_rom();

  always_ff @(posedge clk) begin
    data <= SIN_ROM[addr];
  end

endmodule

FILE: hw/rtl/lpvp_div.sv
// Restoring divider, one quotient bit per cycle, saturating to 15 magnitude bits.
module lpvp_div (
  input  logic                clk,
  input  logic                rst,
  input  lpvp_pkg::div_req_t  req,
  output lpvp_pkg::div_resp_t resp
);

  logic                               busy;
  logic                               done;
  logic                               neg;
  logic [lpvp_pkg::STEP_W-1:0]        step;
  logic [lpvp_pkg::NUM_W-1:0]         rem;
  logic [lpvp_pkg::DEN_W-1:0]         den;
  logic [lpvp_pkg::QB-1:0]            quot;
  logic [lpvp_pkg::CMP_W-1:0]         trial;
  logic [lpvp_pkg::CMP_W-1:0]         limit;
  logic [lpvp_pkg::OUT_W-1:0]         quot_ext;

  assign trial = lpvp_pkg::CMP_W'(den) << step;
  assign limit = lpvp_pkg::CMP_W'(req.den) << lpvp_pkg::QB;
  assign quot_ext = lpvp_pkg::OUT_W'(quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        den <= req.den;
        neg <= req.neg;
        if (lpvp_pkg::CMP_W'(req.num) >= limit) begin
          quot <= '1;
          done <= 1'b1;
        end else begin
          rem <= req.num;
          quot <= '0;
          step <= lpvp_pkg::STEP_W'(lpvp_pkg::QB - 1);
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (lpvp_pkg::CMP_W'(rem) >= trial) begin
          rem <= rem - lpvp_pkg::NUM_W'(trial);
          quot[step] <= 1'b1;
        end
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  assign resp.done = done;
  assign resp.quot = neg ? -quot_ext : quot_ext;

endmodule

FILE: hw/rtl/line_pair_vanishing_point_core.sv
// Top level: line stores, pair walk sequencer, shared multiplier and mean.
//
//  Port group   Dir  Handshake                Payload
//  line         in   line_valid/line_stall    line_distance, line_angle, frame_end
//  point        out  point_valid/point_stall  point_x, point_y, pair_total, lines_dropped
//  cfg          in   cfg_write                cfg_index, cfg_data
//
// A line without frame_end is taken in the idle state. A frame end starts a walk
// over all L*R pairs of L left and R right lines, paced by the single multiplier
// and the one-bit-per-cycle divider shared by every pair; a parallel pair skips the
// divider and a frame without any pair goes straight to the mean.
// Reset clears fills, drop flag and point_valid, sets range bounds; stores need no clear.
// A stalled point beat holds the sequencer at its last step until it is taken.
`include "assert_macros.svh"

module line_pair_vanishing_point_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  line_valid,
  output logic                                  line_stall,
  input  logic signed [lpvp_pkg::DIST_W-1:0]    line_distance,
  input  logic [11:0]                           line_angle,
  input  logic                                  frame_end,
  output logic                                  point_valid,
  input  logic                                  point_stall,
  output logic signed [lpvp_pkg::OUT_W-1:0]     point_x,
  output logic signed [lpvp_pkg::OUT_W-1:0]     point_y,
  output logic [lpvp_pkg::TOTAL_W-1:0]          pair_total,
  output logic                                  lines_dropped,
  input  logic                                  cfg_write,
  input  logic [lpvp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lpvp_pkg::CFG_W-1:0]            cfg_data
);

  typedef enum logic [26:0] {
    S_IDLE   = 27'd1 << 0,
    S_START  = 27'd1 << 1,
    S_LADDR  = 27'd1 << 2,
    S_LSIN   = 27'd1 << 3,
    S_LCOS   = 27'd1 << 4,
    S_RADDR  = 27'd1 << 5,
    S_RWAIT  = 27'd1 << 6,
    S_RSIN   = 27'd1 << 7,
    S_RCOS   = 27'd1 << 8,
    S_M0     = 27'd1 << 9,
    S_M1     = 27'd1 << 10,
    S_M2     = 27'd1 << 11,
    S_M3     = 27'd1 << 12,
    S_M4     = 27'd1 << 13,
    S_M5     = 27'd1 << 14,
    S_M6     = 27'd1 << 15,
    S_XGO    = 27'd1 << 16,
    S_XWAIT  = 27'd1 << 17,
    S_YGO    = 27'd1 << 18,
    S_YWAIT  = 27'd1 << 19,
    S_NEXT   = 27'd1 << 20,
    S_MEAN   = 27'd1 << 21,
    S_MXGO   = 27'd1 << 22,
    S_MXWAIT = 27'd1 << 23,
    S_MYGO   = 27'd1 << 24,
    S_MYWAIT = 27'd1 << 25,
    S_EMIT   = 27'd1 << 26
  } state_t;

  localparam int AB = lpvp_pkg::ANGLE_BITS;
  localparam int DW = lpvp_pkg::DIST_W;

  state_t state, state_next;

  logic [lpvp_pkg::CFG_W-1:0]   left_min, left_max, right_min, right_max;
  logic [lpvp_pkg::FILL_W-1:0]  left_fill, right_fill;
  logic                         drop_seen;

  logic [lpvp_pkg::ENTRY_W-1:0] left_mem  [0:lpvp_pkg::MAX_LINES-1];
  logic [lpvp_pkg::ENTRY_W-1:0] right_mem [0:lpvp_pkg::MAX_LINES-1];
  logic [lpvp_pkg::ENTRY_W-1:0] lrd, rrd;
  logic [lpvp_pkg::IDX_W-1:0]   li, rj;

  logic [AB-1:0]                ang_in, l_ang, r_ang;
  logic signed [DW-1:0]         l_rho, r_rho;
  logic                         in_left, in_right, accept;

  logic [AB-1:0]                rom_addr;
  logic [lpvp_pkg::Q_W-1:0]     rom_q;

  logic signed [lpvp_pkg::QS_W-1:0] sl, cl, sr, cr, rom_pos, rom_cos_l, rom_cos_r;
  logic signed [lpvp_pkg::QS_W-1:0] ma, mb;
  logic signed [lpvp_pkg::P_W-1:0]  p, acc, dd, diff;
  logic signed [lpvp_pkg::NUM_W-1:0] nx, ny;

  logic signed [lpvp_pkg::SUM_W-1:0] sx, sy;
  logic [lpvp_pkg::CNT_W-1:0]        cnt;
  logic signed [lpvp_pkg::OUT_W-1:0] mx;

  lpvp_pkg::div_req_t  div_req;
  lpvp_pkg::div_resp_t div_resp;

  assign ang_in = line_angle[AB-1:0];
  assign in_left = (left_min <= ang_in) && (ang_in <= left_max);
  assign in_right = (right_min <= ang_in) && (ang_in <= right_max);
  assign line_stall = (state != S_IDLE);
  assign accept = line_valid && !line_stall;

  assign l_rho = lrd[lpvp_pkg::ENTRY_W-1:AB];
  assign l_ang = lrd[AB-1:0];
  assign r_rho = rrd[lpvp_pkg::ENTRY_W-1:AB];
  assign r_ang = rrd[AB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      left_min <= lpvp_pkg::CFG_W'(228);
      left_max <= lpvp_pkg::CFG_W'(1365);
      right_min <= lpvp_pkg::CFG_W'(2504);
      right_max <= lpvp_pkg::CFG_W'(3868);
    end else if (cfg_write) begin
      case (cfg_index)
        lpvp_pkg::CFG_IDX_W'(lpvp_pkg::REG_LEFT_MIN): left_min <= cfg_data;
        lpvp_pkg::CFG_IDX_W'(lpvp_pkg::REG_LEFT_MAX): left_max <= cfg_data;
        lpvp_pkg::CFG_IDX_W'(lpvp_pkg::REG_RIGHT_MIN): right_min <= cfg_data;
        lpvp_pkg::CFG_IDX_W'(lpvp_pkg::REG_RIGHT_MAX): right_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_left && left_fill < lpvp_pkg::FILL_W'(lpvp_pkg::MAX_LINES)) begin
      left_mem[left_fill[lpvp_pkg::IDX_W-1:0]] <= {line_distance, ang_in};
    end
    if (accept && !in_left && in_right &&
        right_fill < lpvp_pkg::FILL_W'(lpvp_pkg::MAX_LINES)) begin
      right_mem[right_fill[lpvp_pkg::IDX_W-1:0]] <= {line_distance, ang_in};
    end
    lrd <= left_mem[li];
    rrd <= right_mem[rj];
  end

  lpvp_sin_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  always_comb begin
    case (state)
      S_LSIN:  rom_addr = (l_ang <= AB'(lpvp_pkg::ANGLE_H)) ? l_ang
                          : AB'(lpvp_pkg::ANGLE_N - int'(l_ang));
      S_LCOS:  rom_addr = (l_ang <= AB'(lpvp_pkg::ANGLE_H))
                          ? AB'(lpvp_pkg::ANGLE_H) - l_ang : l_ang - AB'(lpvp_pkg::ANGLE_H);
      S_RSIN:  rom_addr = (r_ang <= AB'(lpvp_pkg::ANGLE_H)) ? r_ang
                          : AB'(lpvp_pkg::ANGLE_N - int'(r_ang));
      S_RCOS:  rom_addr = (r_ang <= AB'(lpvp_pkg::ANGLE_H))
                          ? AB'(lpvp_pkg::ANGLE_H) - r_ang : r_ang - AB'(lpvp_pkg::ANGLE_H);
      default: rom_addr = '0;
    endcase
  end

  assign rom_pos = lpvp_pkg::QS_W'(rom_q);
  assign rom_cos_l = (l_ang > AB'(lpvp_pkg::ANGLE_H)) ? -rom_pos : rom_pos;
  assign rom_cos_r = (r_ang > AB'(lpvp_pkg::ANGLE_H)) ? -rom_pos : rom_pos;

  always_comb begin
    case (state)
      S_M0: begin ma = sl; mb = rom_cos_r; end
      S_M1: begin ma = cl; mb = sr; end
      S_M2: begin ma = lpvp_pkg::QS_W'(r_rho); mb = sl; end
      S_M3: begin ma = lpvp_pkg::QS_W'(l_rho); mb = sr; end
      S_M4: begin ma = lpvp_pkg::QS_W'(l_rho); mb = cr; end
      S_M5: begin ma = lpvp_pkg::QS_W'(r_rho); mb = cl; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign diff = acc - p;

  lpvp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  always_comb begin
    div_req.start = 1'b0;
    div_req.neg = 1'b0;
    div_req.num = '0;
    div_req.den = '0;
    case (state)
      S_XGO, S_YGO: begin
        div_req.start = 1'b1;
        div_req.neg = (state == S_XGO) ? (nx[lpvp_pkg::NUM_W-1] ^ dd[lpvp_pkg::P_W-1])
                                       : (ny[lpvp_pkg::NUM_W-1] ^ dd[lpvp_pkg::P_W-1]);
        div_req.num = (state == S_XGO) ? (nx[lpvp_pkg::NUM_W-1] ? -nx : nx)
                                       : (ny[lpvp_pkg::NUM_W-1] ? -ny : ny);
        div_req.den = dd[lpvp_pkg::P_W-1] ? -dd : dd;
      end
      S_MXGO, S_MYGO: begin
        div_req.start = 1'b1;
        div_req.neg = (state == S_MXGO) ? sx[lpvp_pkg::SUM_W-1] : sy[lpvp_pkg::SUM_W-1];
        div_req.num = (state == S_MXGO)
                      ? lpvp_pkg::NUM_W'(sx[lpvp_pkg::SUM_W-1] ? -sx : sx)
                      : lpvp_pkg::NUM_W'(sy[lpvp_pkg::SUM_W-1] ? -sy : sy);
        div_req.den = lpvp_pkg::DEN_W'(cnt);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept && frame_end) state_next = S_START;
      S_START:  state_next = (left_fill == '0 || right_fill == '0) ? S_MEAN : S_LADDR;
      S_LADDR:  state_next = S_LSIN;
      S_LSIN:   state_next = S_LCOS;
      S_LCOS:   state_next = S_RADDR;
      S_RADDR:  state_next = S_RSIN;
      S_RWAIT:  state_next = S_RSIN;
      S_RSIN:   state_next = S_RCOS;
      S_RCOS:   state_next = S_M0;
      S_M0:     state_next = S_M1;
      S_M1:     state_next = S_M2;
      S_M2:     state_next = S_M3;
      S_M3:     state_next = S_M4;
      S_M4:     state_next = S_M5;
      S_M5:     state_next = S_M6;
      S_M6:     state_next = (dd == '0) ? S_NEXT : S_XGO;
      S_XGO:    state_next = S_XWAIT;
      S_XWAIT:  if (div_resp.done) state_next = S_YGO;
      S_YGO:    state_next = S_YWAIT;
      S_YWAIT:  if (div_resp.done) state_next = S_NEXT;
      S_NEXT: begin
        if (lpvp_pkg::FILL_W'(rj) + 1'b1 < right_fill) begin
          state_next = S_RWAIT;
        end else if (lpvp_pkg::FILL_W'(li) + 1'b1 < left_fill) begin
          state_next = S_LADDR;
        end else begin
          state_next = S_MEAN;
        end
      end
      S_MEAN:   state_next = (cnt == '0) ? S_EMIT : S_MXGO;
      S_MXGO:   state_next = S_MXWAIT;
      S_MXWAIT: if (div_resp.done) state_next = S_MYGO;
      S_MYGO:   state_next = S_MYWAIT;
      S_MYWAIT: if (div_resp.done) state_next = S_EMIT;
      S_EMIT:   if (!point_valid || !point_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      left_fill <= '0;
      right_fill <= '0;
      drop_seen <= 1'b0;
      point_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (point_valid && !point_stall) begin
        point_valid <= 1'b0;
      end
      if (accept) begin
        if (in_left) begin
          if (left_fill < lpvp_pkg::FILL_W'(lpvp_pkg::MAX_LINES)) begin
            left_fill <= left_fill + 1'b1;
          end else begin
            drop_seen <= 1'b1;
          end
        end else if (in_right) begin
          if (right_fill < lpvp_pkg::FILL_W'(lpvp_pkg::MAX_LINES)) begin
            right_fill <= right_fill + 1'b1;
          end else begin
            drop_seen <= 1'b1;
          end
        end
      end
      if (state == S_EMIT && (!point_valid || !point_stall)) begin
        point_valid <= 1'b1;
        left_fill <= '0;
        right_fill <= '0;
        drop_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
    case (state)
      S_START: begin
        li <= '0;
        rj <= '0;
        sx <= '0;
        sy <= '0;
        cnt <= '0;
      end
      S_LCOS:  sl <= rom_pos;
      S_RADDR: cl <= rom_cos_l;
      S_RCOS:  sr <= rom_pos;
      S_M0:    cr <= rom_cos_r;
      S_M1:    acc <= p;
      S_M2:    dd <= diff;
      S_M3:    acc <= p;
      S_M4:    nx <= lpvp_pkg::NUM_W'(diff) <<< lpvp_pkg::SH;
      S_M5:    acc <= p;
      S_M6:    ny <= lpvp_pkg::NUM_W'(diff) <<< lpvp_pkg::SH;
      S_XWAIT: if (div_resp.done) sx <= sx + lpvp_pkg::SUM_W'(div_resp.quot);
      S_YWAIT: begin
        if (div_resp.done) begin
          sy <= sy + lpvp_pkg::SUM_W'(div_resp.quot);
          cnt <= cnt + 1'b1;
        end
      end
      S_NEXT: begin
        if (lpvp_pkg::FILL_W'(rj) + 1'b1 < right_fill) begin
          rj <= rj + 1'b1;
        end else begin
          rj <= '0;
          li <= li + 1'b1;
        end
      end
      S_MEAN:   mx <= '0;
      S_MXWAIT: if (div_resp.done) mx <= div_resp.quot;
      S_EMIT: begin
        if (!point_valid || !point_stall) begin
          point_x <= mx;
          point_y <= (cnt == '0) ? '0 : my_hold;
          pair_total <= lpvp_pkg::TOTAL_W'(cnt);
          lines_dropped <= drop_seen;
        end
      end
      default: ;
    endcase
  end

  logic signed [lpvp_pkg::OUT_W-1:0] my_hold;

  always_ff @(posedge clk) begin
    if (state == S_MYWAIT && div_resp.done) begin
      my_hold <= div_resp.quot;
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, clk, rst, left_fill <= lpvp_pkg::FILL_W'(lpvp_pkg::MAX_LINES) && right_fill <= lpvp_pkg::FILL_W'(lpvp_pkg::MAX_LINES), "store fill beyond capacity")
  `ASSERT_IMPLY(a_busy_stall, clk, rst, state != S_IDLE, line_stall, "line taken while busy")
  `ASSERT_IMPLY(a_emit_src, clk, rst, $rose(point_valid), $past(state == S_EMIT), "point beat not from emit step")

endmodule
